// File: sv/ftpp_pkg.sv
// Shared constants, types and helper functions of the FTP reply parser.
package ftpp_pkg;

  localparam int LINE_MAX_DEFAULT = 128;
  localparam int NUM_MAX          = 6;
  localparam int NUM_IDX_W        = 3;

  localparam logic [7:0] CHAR_NUL   = 8'h00;
  localparam logic [7:0] CHAR_LF    = 8'h0A;
  localparam logic [7:0] CHAR_CR    = 8'h0D;
  localparam logic [7:0] CHAR_SPACE = 8'h20;
  localparam logic [7:0] CHAR_ZERO  = 8'h30;
  localparam logic [7:0] CHAR_NINE  = 8'h39;

  typedef struct packed {
    logic [9:0]  reply_code;
    logic [7:0]  host_a;
    logic [7:0]  host_b;
    logic [7:0]  host_c;
    logic [7:0]  host_d;
    logic [15:0] data_port;
    logic        pasv_found;
  } ftpp_result_t;

  function automatic logic is_digit(input logic [7:0] c);
    is_digit = (c >= CHAR_ZERO) && (c <= CHAR_NINE);
  endfunction

  function automatic logic [3:0] digit_value(input logic [7:0] c);
    logic [7:0] d;
    d = c - CHAR_ZERO;
    digit_value = d[3:0];
  endfunction

endpackage

// File: sv/ftp_reply_code_pasv_parser_core.sv
// Top level of the FTP reply code and PASV address parser.
//
// Bytes of the control connection enter on the input channel, one per
// transfer. Carriage returns are dropped; a line feed closes the line. A line
// that starts with three digits and a space is a final reply and yields one
// transfer on the result channel with the reply code and the first six
// numbers of the text (four host bytes and the data port). Other lines
// yield nothing.
// A byte passes an input register and then the line stage, which updates
// the line state and loads the result register at the same clock edge. The
// result loads after the line feed leaves the input register. One byte is
// taken every cycle as long as the result register is free or being read.
// When the receiver stalls with a result waiting, the input register holds
// one more byte and then the input channel stops until the result is taken.
// Reset clears the line state and both valid flags; no result is pending.
module ftp_reply_code_pasv_parser_core import ftpp_pkg::*; #(
  parameter int LINE_MAX = LINE_MAX_DEFAULT
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  rx_byte,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [9:0]  reply_code,
  output logic [7:0]  host_a,
  output logic [7:0]  host_b,
  output logic [7:0]  host_c,
  output logic [7:0]  host_d,
  output logic [15:0] data_port,
  output logic        pasv_found
);

  logic         held_valid;
  logic [7:0]   held_byte;
  logic         space;
  logic         step;
  logic         fire;
  ftpp_result_t line_result;
  ftpp_result_t out_result;

  assign step = held_valid && space;

  ftpp_in_reg u_in_reg (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .rx_byte    (rx_byte),
    .held_valid (held_valid),
    .held_byte  (held_byte),
    .take       (step)
  );

  ftpp_line #(
    .LINE_MAX (LINE_MAX)
  ) u_line (
    .clk    (clk),
    .rst    (rst),
    .step   (step),
    .c      (held_byte),
    .fire   (fire),
    .result (line_result)
  );

  ftpp_out_reg u_out_reg (
    .clk       (clk),
    .rst       (rst),
    .load      (fire),
    .load_data (line_result),
    .space     (space),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .held      (out_result)
  );

  assign reply_code = out_result.reply_code;
  assign host_a     = out_result.host_a;
  assign host_b     = out_result.host_b;
  assign host_c     = out_result.host_c;
  assign host_d     = out_result.host_d;
  assign data_port  = out_result.data_port;
  assign pasv_found = out_result.pasv_found;

endmodule

// File: sv/ftpp_in_reg.sv
// Input register that holds one received byte until the line stage takes it.
module ftpp_in_reg import ftpp_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] rx_byte,
  output logic       held_valid,
  output logic [7:0] held_byte,
  input  logic       take
);

  assign in_ready = !held_valid || take;

  always_ff @(posedge clk) begin
    if (rst) begin
      held_valid <= 1'b0;
    end else if (in_ready) begin
      held_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      held_byte <= rx_byte;
    end
  end

endmodule

// File: sv/ftpp_line.sv
// Line state, number scan and final reply check, updated once per byte.
module ftpp_line import ftpp_pkg::*; #(
  parameter int LINE_MAX = LINE_MAX_DEFAULT
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         step,
  input  logic [7:0]   c,
  output logic         fire,
  output ftpp_result_t result
);

  localparam int KW = $clog2(LINE_MAX);

  logic [KW-1:0]        chars_kept;
  logic [7:0]           lead_chars [4];
  logic                 text_ended;
  logic [15:0]          number_acc;
  logic                 in_number;
  logic [NUM_IDX_W-1:0] numbers_found;
  logic [7:0]           found_values [NUM_MAX];

  logic                 is_cr;
  logic                 is_lf;
  logic                 keep;
  logic                 lead;
  logic                 scan;
  logic                 is_final;
  logic                 store_open;
  logic [7:0]           fv_final [NUM_MAX];
  logic [15:0]          acc_next;
  logic [9:0]           code;

  assign is_cr = (c == CHAR_CR);
  assign is_lf = (c == CHAR_LF);
  assign keep  = !is_cr && !is_lf && (chars_kept < KW'(LINE_MAX - 1));
  assign lead  = chars_kept < KW'(4);
  assign scan  = keep && !lead && !text_ended && (numbers_found < NUM_IDX_W'(NUM_MAX));

  assign acc_next = (number_acc << 3) + (number_acc << 1) + 16'(digit_value(c));

  assign is_final = !lead && is_digit(lead_chars[0]) && is_digit(lead_chars[1]) &&
                    is_digit(lead_chars[2]) && (lead_chars[3] == CHAR_SPACE);
  assign fire = step && is_lf && is_final;

  assign store_open = in_number && (numbers_found < NUM_IDX_W'(NUM_MAX));

  always_comb begin
    for (int i = 0; i < NUM_MAX; i++) begin
      if (store_open && (numbers_found == NUM_IDX_W'(i))) begin
        fv_final[i] = number_acc[7:0];
      end else begin
        fv_final[i] = found_values[i];
      end
    end
  end

  assign code = 10'(digit_value(lead_chars[0])) * 10'd100 +
                10'(digit_value(lead_chars[1])) * 10'd10 +
                10'(digit_value(lead_chars[2]));

  always_comb begin
    result.reply_code = code;
    result.host_a     = fv_final[0];
    result.host_b     = fv_final[1];
    result.host_c     = fv_final[2];
    result.host_d     = fv_final[3];
    result.data_port  = {fv_final[4], fv_final[5]};
    result.pasv_found = (numbers_found == NUM_IDX_W'(NUM_MAX)) ||
                        (in_number && (numbers_found == NUM_IDX_W'(NUM_MAX - 1)));
  end

  always_ff @(posedge clk) begin
    if (rst || (step && is_lf)) begin
      chars_kept    <= '0;
      text_ended    <= 1'b0;
      number_acc    <= '0;
      in_number     <= 1'b0;
      numbers_found <= '0;
      for (int i = 0; i < 4; i++) begin
        lead_chars[i] <= '0;
      end
      for (int i = 0; i < NUM_MAX; i++) begin
        found_values[i] <= '0;
      end
    end else if (step && keep) begin
      chars_kept <= chars_kept + KW'(1);
      if (lead) begin
        lead_chars[chars_kept[1:0]] <= c;
      end else if (scan) begin
        if (c == CHAR_NUL) begin
          text_ended <= 1'b1;
        end else if (is_digit(c)) begin
          number_acc <= acc_next;
          in_number  <= 1'b1;
        end else if (in_number) begin
          found_values[numbers_found] <= number_acc[7:0];
          numbers_found <= numbers_found + NUM_IDX_W'(1);
          number_acc    <= '0;
          in_number     <= 1'b0;
        end
      end
    end
  end

endmodule

// File: sv/ftpp_out_reg.sv
// Result register that holds one parsed reply until the receiver takes it.
module ftpp_out_reg import ftpp_pkg::*; (
  input  logic         clk,
  input  logic         rst,
  input  logic         load,
  input  ftpp_result_t load_data,
  output logic         space,
  output logic         out_valid,
  input  logic         out_ready,
  output ftpp_result_t held
);

  assign space = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      held <= load_data;
    end
  end

endmodule
